// ===== rtl/keyed_event_stats_table_defines.svh =====
// ----------------------------------------------------------------------------
// keyed_event_stats_table_defines
// Assertion macros used by the statistics table top level.
// ----------------------------------------------------------------------------
`ifndef KEYED_EVENT_STATS_TABLE_DEFINES_SVH
`define KEYED_EVENT_STATS_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define KEST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define KEST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kest_pkg.sv =====
// ----------------------------------------------------------------------------
// kest_pkg
// Types, sizes, codes and helpers of the keyed event statistics table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kest_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int KIND_BITS     = 4;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int QUEUE_DEPTH   = 2;  // power of two
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // func field codes
    localparam logic [1:0] FN_ACCUM  = 2'd0;
    localparam logic [1:0] FN_LOOKUP = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;

    // classified operations
    localparam logic [2:0] OP_ACC   = 3'd0;
    localparam logic [2:0] OP_SKIP  = 3'd1;
    localparam logic [2:0] OP_LOOK  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_MISS  = 3'd4;

    // result status codes
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_SKIPPED  = 3'd3;
    localparam logic [2:0] ST_HIT      = 3'd4;
    localparam logic [2:0] ST_MISS     = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    typedef struct packed {
        logic [1:0]         func;
        logic [63:0]        name_hash;
        logic [3:0]         kind;
        logic signed [63:0] value;
        logic               name_present;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         slot;
        logic [31:0]        entry_count;
        logic signed [63:0] entry_total;
        logic signed [63:0] entry_maximum;
        logic [3:0]         entry_kind;
        logic [5:0]         used_entries;
        logic [31:0]        overflow_count;
    } t_out;

    typedef struct packed {
        logic [2:0]           op;
        logic [63:0]          name_hash;
        logic [KIND_BITS-1:0] kind;
        logic signed [63:0]   value;
    } t_req;

    function automatic logic [KIND_BITS-1:0] to_kind_in(input logic [3:0] k);
        logic [KIND_BITS+3:0] w;
        w = {KIND_BITS'(0), k};
        return w[KIND_BITS-1:0];
    endfunction

    function automatic logic [3:0] to_kind_out(input logic [KIND_BITS-1:0] k);
        logic [KIND_BITS+3:0] w;
        w = {4'b0, k};
        return w[3:0];
    endfunction

    function automatic logic [4:0] to_slot(input logic [IDX_W-1:0] i);
        logic [IDX_W+4:0] w;
        w = {5'b0, i};
        return w[4:0];
    endfunction

    function automatic logic [5:0] to_used(input logic [USED_W-1:0] u);
        logic [USED_W+5:0] w;
        w = {6'b0, u};
        return w[5:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kest_front.sv =====
// ----------------------------------------------------------------------------
// kest_front
// Request intake: takes a request when the queue has room and classifies it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kest_front import kest_pkg::*; (
    input  logic i_start,
    input  t_in  i_in,
    input  logic i_full,
    output logic o_busy,
    output logic o_push,
    output t_req o_req
);

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_req.name_hash = i_in.name_hash;
        o_req.kind      = to_kind_in(i_in.kind);
        o_req.value     = i_in.value;
        case (i_in.func)
            FN_ACCUM:  o_req.op = i_in.name_present ? OP_ACC : OP_SKIP;
            FN_LOOKUP: o_req.op = OP_LOOK;
            FN_CLEAR:  o_req.op = OP_CLEAR;
            default:   o_req.op = OP_MISS;  // unused func code acts as a miss
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/kest_queue.sv =====
// ----------------------------------------------------------------------------
// kest_queue
// Short FIFO of classified requests between intake and table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kest_queue import kest_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_wdata,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_req o_rdata
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kest_back.sv =====
// ----------------------------------------------------------------------------
// kest_back
// Table engine: key search with stats read, then update, write and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kest_back import kest_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_req i_q_req,
    output logic o_pop,
    output logic o_strobe,
    output t_out o_res
);

    typedef struct packed {
        logic [31:0]        count;
        logic signed [63:0] total;
        logic signed [63:0] maximum;
    } t_stats;

    localparam logic P_LOOK = 1'b0;
    localparam logic P_EXEC = 1'b1;

    // key cells, compared in parallel
    logic [63:0]          r_key_hash [TABLE_ENTRIES];
    logic [KIND_BITS-1:0] r_key_kind [TABLE_ENTRIES];
    // per-entry statistics memory
    t_stats               r_stats    [TABLE_ENTRIES];

    logic              r_phase;
    logic [USED_W-1:0] r_used, n_used;
    logic [31:0]       r_ovf, n_ovf;
    t_req              r_req;
    logic              r_hit;
    logic [IDX_W-1:0]  r_idx;
    t_stats            r_rd;
    logic              r_strobe;
    t_out              r_res, n_res;

    logic [TABLE_ENTRIES-1:0] hit_hash, hit_full, hit_sel, hit_first;
    logic [IDX_W-1:0]         idx_first, idx_bits;
    logic                     tbl_full, wr_en, ins;
    logic [IDX_W-1:0]         wr_idx;
    t_stats                   base, upd;

    // search: only entries below the fill count take part
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_hash[i] = (USED_W'(i) < r_used) && (r_key_hash[i] == i_q_req.name_hash);
            hit_full[i] = hit_hash[i] && (r_key_kind[i] == i_q_req.kind);
        end
        hit_sel   = (i_q_req.op == OP_ACC) ? hit_full : hit_hash;
        hit_first = hit_sel & (~hit_sel + TABLE_ENTRIES'(1));  // lowest hit only
        idx_first = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            idx_bits  = IDX_W'(i);
            idx_first = idx_first | (idx_bits & {IDX_W{hit_first[i]}});
        end
    end

    assign o_pop = (r_phase == P_LOOK) && i_q_valid;

    // update and result
    always_comb begin
        tbl_full = (r_used == USED_W'(TABLE_ENTRIES));
        n_used   = r_used;
        n_ovf    = r_ovf;
        wr_en    = 1'b0;
        ins      = 1'b0;
        wr_idx   = r_idx;
        base     = r_rd;
        n_res    = '0;
        case (r_req.op)
            OP_ACC: begin
                if (r_hit) begin
                    wr_en        = 1'b1;
                    n_res.status = ST_UPDATED;
                end else if (tbl_full) begin
                    if (r_ovf != '1) begin
                        n_ovf = r_ovf + 32'd1;
                    end
                    n_res.status = ST_DROPPED;
                end else begin
                    wr_en        = 1'b1;
                    ins          = 1'b1;
                    wr_idx       = r_used[IDX_W-1:0];
                    base         = '0;
                    n_used       = r_used + USED_W'(1);
                    n_res.status = ST_INSERTED;
                end
            end
            OP_LOOK: begin
                if (r_hit) begin
                    n_res.status        = ST_HIT;
                    n_res.slot          = to_slot(r_idx);
                    n_res.entry_count   = r_rd.count;
                    n_res.entry_total   = r_rd.total;
                    n_res.entry_maximum = r_rd.maximum;
                    n_res.entry_kind    = to_kind_out(r_key_kind[r_idx]);
                end else begin
                    n_res.status = ST_MISS;
                end
            end
            OP_SKIP: begin
                n_res.status = ST_SKIPPED;
            end
            OP_CLEAR: begin
                n_used       = '0;
                n_ovf        = '0;
                n_res.status = ST_CLEARED;
            end
            default: begin
                n_res.status = ST_MISS;
            end
        endcase

        upd.count   = (base.count == '1) ? base.count : base.count + 32'd1;
        upd.total   = base.total + r_req.value;
        upd.maximum = ($signed(r_req.value) > $signed(base.maximum)) ? r_req.value
                                                                      : base.maximum;
        if (wr_en) begin
            n_res.slot          = to_slot(wr_idx);
            n_res.entry_count   = upd.count;
            n_res.entry_total   = upd.total;
            n_res.entry_maximum = upd.maximum;
            n_res.entry_kind    = to_kind_out(r_req.kind);
        end
        n_res.used_entries   = to_used(n_used);
        n_res.overflow_count = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= P_LOOK;
            r_used   <= '0;
            r_ovf    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (r_phase == P_EXEC) begin
                r_phase  <= P_LOOK;
                r_used   <= n_used;
                r_ovf    <= n_ovf;
                r_strobe <= 1'b1;
            end else if (o_pop) begin
                r_phase <= P_EXEC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req <= i_q_req;
            r_hit <= |hit_sel;
            r_idx <= idx_first;
        end
        if (r_phase == P_EXEC) begin
            r_res <= n_res;
        end
    end

    // key cells
    always_ff @(posedge i_clk) begin
        if ((r_phase == P_EXEC) && ins) begin
            r_key_hash[wr_idx] <= r_req.name_hash;
            r_key_kind[wr_idx] <= r_req.kind;
        end
    end

    // stats memory: registered read in the search cycle, write in the update cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_stats[idx_first];
        end
        if ((r_phase == P_EXEC) && wr_en) begin
            r_stats[wr_idx] <= upd;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire

// ===== rtl/keyed_event_stats_table.sv =====
// ----------------------------------------------------------------------------
// keyed_event_stats_table
// Keyed event statistics table with request queue and search/update engine.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. Every
// request gives exactly one result, shown on o_res for one cycle with
// o_strobe high; the receiver cannot stall it, so capture it on that edge.
// The table engine handles a request in a search phase and an update phase:
// the search phase compares the key against all key cells and reads the
// stats memory at the first hit, the update phase updates, writes back and
// registers the result. The engine takes no new request from the queue until
// it has finished the last one. A two-entry queue sits in front of the
// engine; busy is high while it is full. No clearing pass runs after reset:
// the fill count alone says which entries are live, and clear just zeroes
// it together with the overflow counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_event_stats_table_defines.svh"

module keyed_event_stats_table import kest_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_req,
    output logic busy,
    output logic o_strobe,
    output t_out o_res
);

    // intake to queue
    logic push;
    t_req push_req;
    logic q_full;

    // queue to engine
    logic q_valid;
    logic q_pop;
    t_req q_req;

    kest_front u_front (
        .i_start (start),
        .i_in    (i_req),
        .i_full  (q_full),
        .o_busy  (busy),
        .o_push  (push),
        .o_req   (push_req)
    );

    kest_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rdata (q_req)
    );

    kest_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_req   (q_req),
        .o_pop     (q_pop),
        .o_strobe  (o_strobe),
        .o_res     (o_res)
    );

    // the engine never finishes two requests in consecutive cycles
    `KEST_ASSERT_NEXT(a_strobe_spacing, o_strobe, !o_strobe, "back-to-back result strobes")
    // clear leaves an empty table and a zero overflow count
    `KEST_ASSERT_NOW(a_clear_zeroes, o_strobe && (o_res.status == ST_CLEARED),
        (o_res.used_entries == 6'd0) && (o_res.overflow_count == 32'd0),
        "clear result with nonzero counts")
    // a drop only happens on a full table
    `KEST_ASSERT_NOW(a_drop_full, o_strobe && (o_res.status == ST_DROPPED),
        o_res.used_entries == to_used(USED_W'(TABLE_ENTRIES)), "drop while table not full")
    // fill count never runs past the table size
    `KEST_ASSERT_NOW(a_used_bound, o_strobe,
        o_res.used_entries <= to_used(USED_W'(TABLE_ENTRIES)), "used entries out of range")

endmodule

`default_nettype wire
